>>> sv/bcc_pkg.sv
package bcc_pkg;

  typedef enum logic [1:0] {
    CmdEdge   = 2'd0,
    CmdTick   = 2'd1,
    CmdQuery  = 2'd2,
    CmdUnused = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ModeNone   = 2'd0,
    ModeSingle = 2'd1,
    ModeDouble = 2'd2,
    ModeLong   = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegWindowTicks   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegActiveButtons = 1'd1;

  localparam int unsigned TicksW  = 16;
  localparam int unsigned ActiveW = 5;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned ButtonW = 4;
  localparam int unsigned CountW  = 2;

  localparam logic [TicksW-1:0]  WindowTicksRst = 16'd300;
  localparam logic [CountW-1:0]  CountMax       = 2'd3;

endpackage

>>> sv/button_click_classifier_top.sv
// Channel  Signals                                   Direction
// -------  ----------------------------------------  ---------
// in       in_valid_i/in_ready_o, cmd_i, button_i,    sink
//          port_i, levels_a_i, levels_b_i
// out      out_valid_o/out_ready_i, mode_o,           source
//          window_closed_o
// cfg      cfg_valid_i/cfg_ready_o, cfg_index_i,      sink
//          cfg_data_i
//
// Each item passes through the input register and then the result register,
// with one item accepted per cycle while the result register is not stalled.
// The per-button state sits in flip-flops, so a window close updates every
// active button in the same cycle. Reset clears it with no clearing pass.
// A stalled result holds the result register; the input register keeps
// accepting while the result register is free or being drained.
module button_click_classifier_top
  import bcc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic [ButtonW-1:0]   button_i,
  input  logic                 port_i,
  input  logic [LevelW-1:0]    levels_a_i,
  input  logic [LevelW-1:0]    levels_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           mode_o,
  output logic                 window_closed_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [TicksW-1:0]    cfg_data_i
);

  logic [TicksW-1:0]  window_ticks_q;
  logic [ActiveW-1:0] active_buttons_q;

  logic               stg_valid_q;
  cmd_e               stg_cmd_q;
  logic [ButtonW-1:0] stg_button_q;
  logic               stg_port_q;
  logic [LevelW-1:0]  stg_levels_a_q;
  logic [LevelW-1:0]  stg_levels_b_q;

  logic [NUM_BUTTONS-1:0] pending_q, pending_d;
  logic [NUM_BUTTONS-1:0] port_q, port_d;
  logic [CountW-1:0]      count_q [NUM_BUTTONS];
  logic [CountW-1:0]      count_d [NUM_BUTTONS];
  mode_e                  mode_q  [NUM_BUTTONS];
  mode_e                  mode_d  [NUM_BUTTONS];
  logic                   window_open_q, window_open_d;
  logic [TicksW-1:0]      ticks_left_q, ticks_left_d;

  logic        out_valid_q;
  logic [1:0]  out_mode_q, out_mode_d;
  logic        out_closed_q, out_closed_d;

  logic        advance;
  logic        in_xfer;
  logic        btn_ok;
  logic        close_win;
  logic [31:0] lev_a_ext;
  logic [31:0] lev_b_ext;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign advance     = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !stg_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o     = out_valid_q;
  assign mode_o          = out_mode_q;
  assign window_closed_o = out_closed_q;

  assign btn_ok    = int'(stg_button_q) < int'(NUM_BUTTONS);
  assign lev_a_ext = {16'd0, stg_levels_a_q};
  assign lev_b_ext = {16'd0, stg_levels_b_q};
  assign close_win = (stg_cmd_q == CmdTick) && window_open_q && (ticks_left_q <= 16'd1);

  always_comb begin
    pending_d     = pending_q;
    port_d        = port_q;
    count_d       = count_q;
    mode_d        = mode_q;
    window_open_d = window_open_q;
    ticks_left_d  = ticks_left_q;
    out_mode_d    = ModeNone;
    out_closed_d  = 1'b0;
    unique case (stg_cmd_q)
      CmdEdge: begin
        if (btn_ok) begin
          for (int i = 0; i < int'(NUM_BUTTONS); i++) begin
            if (int'(stg_button_q) == i) begin
              port_d[i]    = stg_port_q;
              pending_d[i] = 1'b1;
              if (count_q[i] != CountMax) begin
                count_d[i] = count_q[i] + 2'd1;
              end
            end
          end
          if (!window_open_q) begin
            window_open_d = 1'b1;
            ticks_left_d  = window_ticks_q;
          end
        end
      end
      CmdTick: begin
        if (close_win) begin
          for (int i = 0; i < int'(NUM_BUTTONS); i++) begin
            if (5'(i) < active_buttons_q) begin
              if (!pending_q[i]) begin
                mode_d[i] = ModeNone;
              end else if (count_q[i] > 2'd1) begin
                mode_d[i] = ModeDouble;
              end else if (port_q[i] ? lev_b_ext[i] : lev_a_ext[i]) begin
                mode_d[i] = ModeLong;
              end else begin
                mode_d[i] = ModeSingle;
              end
              pending_d[i] = 1'b0;
              count_d[i]   = '0;
            end
          end
          window_open_d = 1'b0;
          ticks_left_d  = '0;
          out_closed_d  = 1'b1;
        end else if (window_open_q) begin
          ticks_left_d = ticks_left_q - 16'd1;
        end
      end
      CmdQuery, CmdUnused: begin
      end
      default: begin
      end
    endcase
    for (int i = 0; i < int'(NUM_BUTTONS); i++) begin
      if (int'(stg_button_q) == i) begin
        out_mode_d = mode_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ticks_q   <= WindowTicksRst;
      active_buttons_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == RegWindowTicks) begin
        window_ticks_q <= cfg_data_i;
      end else if (cfg_index_i == RegActiveButtons) begin
        active_buttons_q <= (int'(cfg_data_i[ActiveW-1:0]) > int'(NUM_BUTTONS))
                            ? ActiveW'(NUM_BUTTONS) : cfg_data_i[ActiveW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      stg_cmd_q      <= cmd_e'(cmd_i);
      stg_button_q   <= button_i;
      stg_port_q     <= port_i;
      stg_levels_a_q <= levels_a_i;
      stg_levels_b_q <= levels_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      port_q        <= '0;
      window_open_q <= 1'b0;
      ticks_left_q  <= '0;
      for (int i = 0; i < int'(NUM_BUTTONS); i++) begin
        count_q[i] <= '0;
        mode_q[i]  <= ModeNone;
      end
    end else if (advance) begin
      pending_q     <= pending_d;
      port_q        <= port_d;
      window_open_q <= window_open_d;
      ticks_left_q  <= ticks_left_d;
      count_q       <= count_d;
      mode_q        <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mode_q   <= out_mode_d;
      out_closed_q <= out_closed_d;
    end
  end

endmodule
